// ===== sv/quad_motor_mixer_ramp_limit_assert.svh =====
// assertion macros for the quad motor mixer
`ifndef QUAD_MOTOR_MIXER_RAMP_LIMIT_ASSERT_SVH
`define QUAD_MOTOR_MIXER_RAMP_LIMIT_ASSERT_SVH

// same-cycle implication
`define QMM_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("qmm assertion failed");

// next-cycle implication
`define QMM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("qmm assertion failed");

`endif

// ===== sv/qmm_pkg.sv =====
// shared types, constants and arithmetic steps for the quad motor mixer
`default_nettype none
package qmm_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int LANES         = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int MAXDV_W       = 31;
   localparam int RAD_W         = 64;
   localparam int ROOT_W        = 32;
   localparam int REM_W         = ROOT_W + 4;
   localparam int SQRT_PER_CYC  = 2;
   localparam int SQRT_CYCLES   = ROOT_W / SQRT_PER_CYC;
   localparam int SCNT_W        = $clog2(SQRT_CYCLES);
   localparam int DIV_W         = 32;
   localparam int DIV_PER_CYC   = 2;
   localparam int DIV_CYCLES    = DIV_W / DIV_PER_CYC;
   localparam int DCNT_W        = $clog2(DIV_CYCLES);
   localparam int PROD_W        = DATA_W + MAXDV_W;

   typedef logic signed [DATA_W-1:0] sword_type;
   typedef logic [DATA_W-1:0] uword_type;

   localparam sword_type S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam sword_type S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_YAW_GAIN    = 3'd0,
      CSR_INV_THRUST  = 3'd1,
      CSR_YAW_REVERSE = 3'd2,
      CSR_RAMP_ENABLE = 3'd3,
      CSR_MAX_DELTA_V = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic in_ready;
      logic out_valid;
   } lane_hs_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_acc_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] quo;
   } div_acc_type;

   function automatic sword_type sat_s32(input logic signed [63:0] v);
      sword_type res;
      if (v > 64'sh000000007fffffff) begin
         res = S32_MAX;
      end else if (v < 64'shffffffff80000000) begin
         res = S32_MIN;
      end else begin
         res = v[DATA_W-1:0];
      end
      return res;
   endfunction

   // one radix-4 digit of the restoring square root
   function automatic sqrt_acc_type sqrt_step(input sqrt_acc_type a, input logic [1:0] pair);
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] trial;
      sqrt_acc_type o;
      r = {a.rem[REM_W-3:0], pair};
      trial = {{(REM_W-ROOT_W-2){1'b0}}, a.root, 2'b01};
      if (r >= trial) begin
         o.rem = r - trial;
         o.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem = r;
         o.root = {a.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // one quotient bit of the restoring divide
   function automatic div_acc_type div_step(input div_acc_type a, input logic nbit,
                                            input uword_type d);
      logic [DIV_W:0] r;
      div_acc_type o;
      r = {a.rem, nbit};
      if (r >= {1'b0, d}) begin
         r = r - {1'b0, d};
         o.quo = {a.quo[DIV_W-2:0], 1'b1};
      end else begin
         o.quo = {a.quo[DIV_W-2:0], 1'b0};
      end
      o.rem = r[DIV_W-1:0];
      return o;
   endfunction
endpackage
`default_nettype wire

// ===== sv/qmm_if.sv =====
// request and response channel interfaces of the quad motor mixer
`default_nettype none
interface qmm_req_if;
   logic valid;
   logic ready;
   qmm_pkg::sword_type total_thrust;
   qmm_pkg::sword_type roll_moment;
   qmm_pkg::sword_type pitch_moment;
   qmm_pkg::sword_type yaw_moment;
   qmm_pkg::sword_type now_vel_fl;
   qmm_pkg::sword_type now_vel_fr;
   qmm_pkg::sword_type now_vel_rl;
   qmm_pkg::sword_type now_vel_rr;
   modport source (output valid, total_thrust, roll_moment, pitch_moment, yaw_moment,
                   now_vel_fl, now_vel_fr, now_vel_rl, now_vel_rr, input ready);
   modport sink (input valid, total_thrust, roll_moment, pitch_moment, yaw_moment,
                 now_vel_fl, now_vel_fr, now_vel_rl, now_vel_rr, output ready);
endinterface

interface qmm_rsp_if;
   logic valid;
   logic ready;
   qmm_pkg::sword_type out_vel_fl;
   qmm_pkg::sword_type out_vel_fr;
   qmm_pkg::sword_type out_vel_rl;
   qmm_pkg::sword_type out_vel_rr;
   logic ramp_limited;
   modport source (output valid, out_vel_fl, out_vel_fr, out_vel_rl, out_vel_rr,
                   ramp_limited, input ready);
   modport sink (input valid, out_vel_fl, out_vel_fr, out_vel_rl, out_vel_rr,
                 ramp_limited, output ready);
endinterface
`default_nettype wire

// ===== sv/quad_motor_mixer_ramp_limit.sv =====
// a request passes 3 mixing stages, the iterative square root lanes, 2 merge stages,
// the iterative divide lanes and the output register on its way to a response
// throughput is set by the square root and divide lanes, which take no new request until
// done, each retire two bits per cycle and overlap with each other and with mixing
// reset: synchronous active high, empties all stages, registers return to defaults
`default_nettype none
module quad_motor_mixer_ramp_limit #(
   parameter int FRAC_BITS = qmm_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   qmm_req_if.sink req_chan,
   qmm_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [qmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qmm_pkg::DATA_W-1:0] csr_wdata
);
   import qmm_pkg::*;

   localparam uword_type ONE = DATA_W'(1) << FRAC_BITS;

   uword_type gain_ff, inv_ff;
   logic rev_ff, ramp_en_ff;
   logic [MAXDV_W-1:0] maxdv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= ONE;
         inv_ff <= ONE;
         rev_ff <= 1'b0;
         ramp_en_ff <= 1'b1;
         maxdv_ff <= ONE[MAXDV_W-1:0];
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_YAW_GAIN:    gain_ff <= csr_wdata;
            CSR_INV_THRUST:  inv_ff <= csr_wdata;
            CSR_YAW_REVERSE: rev_ff <= csr_wdata[0];
            CSR_RAMP_ENABLE: ramp_en_ff <= csr_wdata[0];
            CSR_MAX_DELTA_V: maxdv_ff <= csr_wdata[MAXDV_W-1:0];
            default: ;
         endcase
      end
   end

   // mixing front end
   sword_type req_now [LANES];
   logic mix_valid;
   logic [RAD_W-1:0] mix_rad [LANES];
   sword_type mix_now [LANES];
   logic sq_all_ready, sq_all_done, sq_start;
   logic [LANES-1:0] sq_rdy, sq_done;

   assign req_now[0] = req_chan.now_vel_fl;
   assign req_now[1] = req_chan.now_vel_fr;
   assign req_now[2] = req_chan.now_vel_rl;
   assign req_now[3] = req_chan.now_vel_rr;

   qmm_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
      .clock(clock), .reset(reset),
      .in_valid(req_chan.valid), .in_ready(req_chan.ready),
      .total_thrust(req_chan.total_thrust), .roll_moment(req_chan.roll_moment),
      .pitch_moment(req_chan.pitch_moment), .yaw_moment(req_chan.yaw_moment),
      .now_vel(req_now), .yaw_gain(gain_ff), .inv_thrust(inv_ff), .yaw_rev(rev_ff),
      .out_valid(mix_valid), .out_ready(sq_all_ready),
      .rad(mix_rad), .now_out(mix_now)
   );

   // square root lanes, started together and finishing together
   lane_hs_type sq_hs [LANES];
   logic [ROOT_W-1:0] sq_root [LANES];
   sword_type sq_now_ff [LANES];
   logic mg_in_ready;

   assign sq_all_ready = &sq_rdy;
   assign sq_all_done = &sq_done;
   assign sq_start = mix_valid && sq_all_ready;

   for (genvar i = 0; i < LANES; i++) begin : g_sqrt
      assign sq_rdy[i] = sq_hs[i].in_ready;
      assign sq_done[i] = sq_hs[i].out_valid;
      qmm_sqrt u_sqrt (
         .clock(clock), .reset(reset),
         .in_valid(sq_start), .rad(mix_rad[i]),
         .out_ready(mg_in_ready && sq_all_done),
         .hs(sq_hs[i]), .root(sq_root[i])
      );
   end

   always_ff @(posedge clock) begin
      if (sq_start) sq_now_ff <= mix_now;
   end

   // merge of lane results
   logic mg_valid, mg_lim;
   logic [PROD_W-1:0] mg_prod [LANES];
   uword_type mg_max;
   sword_type mg_vel [LANES];
   sword_type mg_now [LANES];
   logic [LANES-1:0] mg_neg;
   logic dv_all_ready, dv_all_done, dv_start;
   logic [LANES-1:0] dv_rdy, dv_done;

   qmm_merge u_merge (
      .clock(clock), .reset(reset),
      .in_valid(sq_all_done), .in_ready(mg_in_ready),
      .root(sq_root), .now_vel(sq_now_ff),
      .ramp_en(ramp_en_ff), .max_dv(maxdv_ff),
      .out_valid(mg_valid), .out_ready(dv_all_ready),
      .prod(mg_prod), .max_abs(mg_max), .limited(mg_lim),
      .vel(mg_vel), .now_out(mg_now), .neg(mg_neg)
   );

   // divide lanes scale each change by allowed over largest
   lane_hs_type dv_hs [LANES];
   uword_type dv_quo [LANES];
   sword_type dv_vel_ff [LANES];
   sword_type dv_now_ff [LANES];
   logic [LANES-1:0] dv_neg_ff;
   logic dv_lim_ff;
   logic rsp_en, div_take;

   assign dv_all_ready = &dv_rdy;
   assign dv_all_done = &dv_done;
   assign dv_start = mg_valid && dv_all_ready;
   assign rsp_en = !rsp_chan.valid || rsp_chan.ready;
   assign div_take = dv_all_done && rsp_en;

   for (genvar i = 0; i < LANES; i++) begin : g_div
      assign dv_rdy[i] = dv_hs[i].in_ready;
      assign dv_done[i] = dv_hs[i].out_valid;
      qmm_div u_div (
         .clock(clock), .reset(reset),
         .in_valid(dv_start), .num(mg_prod[i]), .den(mg_max),
         .out_ready(div_take),
         .hs(dv_hs[i]), .quo(dv_quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (dv_start) begin
         dv_vel_ff <= mg_vel;
         dv_now_ff <= mg_now;
         dv_neg_ff <= mg_neg;
         dv_lim_ff <= mg_lim;
      end
   end

   // output register
   sword_type fin_in [LANES];
   sword_type rsp_vel_ff [LANES];
   logic rsp_valid_ff, rsp_lim_ff;
   logic signed [DATA_W+1:0] sc, fin;

   always_comb begin
      sc = '0;
      fin = '0;
      for (int i = 0; i < LANES; i++) begin
         sc = dv_neg_ff[i] ? -$signed({2'b00, dv_quo[i]}) : $signed({2'b00, dv_quo[i]});
         fin = (DATA_W+2)'(dv_now_ff[i]) + sc;
         fin_in[i] = dv_lim_ff ? sat_s32(64'(fin)) : dv_vel_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_en) begin
         rsp_valid_ff <= div_take;
      end
   end

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_vel_ff <= fin_in;
         rsp_lim_ff <= dv_lim_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_vel_fl = rsp_vel_ff[0];
   assign rsp_chan.out_vel_fr = rsp_vel_ff[1];
   assign rsp_chan.out_vel_rl = rsp_vel_ff[2];
   assign rsp_chan.out_vel_rr = rsp_vel_ff[3];
   assign rsp_chan.ramp_limited = rsp_lim_ff;

`include "quad_motor_mixer_ramp_limit_assert.svh"

   // lanes run in lockstep
   `QMM_ASSERT_NOW(a_sqrt_lockstep, clock, reset, sq_done[0], sq_all_done)
   `QMM_ASSERT_NOW(a_div_lockstep, clock, reset, dv_done[0], dv_all_done)
   // a taken response with nothing behind it leaves the output empty
   `QMM_ASSERT_NEXT(a_rsp_drain, clock, reset,
      rsp_valid_ff && rsp_chan.ready && !div_take, !rsp_valid_ff)
   // scaling only ever happens with ramp limiting on
   `QMM_ASSERT_NOW(a_lim_needs_ramp, clock, reset, rsp_valid_ff && rsp_lim_ff, ramp_en_ff)
endmodule
`default_nettype wire

// ===== sv/qmm_mix.sv =====
// yaw scaling, x-frame mixing and radicand multiply, three register stages
`default_nettype none
module qmm_mix #(
   parameter int FRAC_BITS = qmm_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  qmm_pkg::sword_type total_thrust,
   input  qmm_pkg::sword_type roll_moment,
   input  qmm_pkg::sword_type pitch_moment,
   input  qmm_pkg::sword_type yaw_moment,
   input  qmm_pkg::sword_type now_vel [qmm_pkg::LANES],
   input  qmm_pkg::uword_type yaw_gain,
   input  qmm_pkg::uword_type inv_thrust,
   input  logic yaw_rev,
   output logic out_valid,
   input  logic out_ready,
   output logic [qmm_pkg::RAD_W-1:0] rad [qmm_pkg::LANES],
   output qmm_pkg::sword_type now_out [qmm_pkg::LANES]
);
   import qmm_pkg::*;

   logic v0_ff, v1_ff, v2_ff;
   logic en0, en1, en2;
   logic signed [2*DATA_W:0] prod_full;
   logic signed [63:0] prod0_ff;
   sword_type t0_ff, r0_ff, p0_ff;
   sword_type now0_ff [LANES];
   sword_type now1_ff [LANES];
   sword_type now2_ff [LANES];
   sword_type thr_in [LANES];
   sword_type thr1_ff [LANES];
   logic [RAD_W-1:0] rad_in [LANES];
   logic [RAD_W-1:0] rad2_ff [LANES];
   logic signed [63:0] yaw_sh;
   sword_type yaw_eq, yaw_fin;
   logic signed [DATA_W+2:0] sum [LANES];
   logic signed [DATA_W+2:0] tx, rx, px, yx;
   logic [2*DATA_W-2:0] mprod;

   always_comb begin
      en2 = !v2_ff || out_ready;
      en1 = !v1_ff || en2;
      en0 = !v0_ff || en1;
      in_ready = en0;
      out_valid = v2_ff;
      prod_full = yaw_moment * $signed({1'b0, yaw_gain});
   end

   always_comb begin
      yaw_sh = prod0_ff >>> FRAC_BITS;
      yaw_eq = sat_s32(yaw_sh);
      yaw_fin = yaw_rev ? sat_s32(-(64'(yaw_eq))) : yaw_eq;
      tx = (DATA_W+3)'(t0_ff);
      rx = (DATA_W+3)'(r0_ff);
      px = (DATA_W+3)'(p0_ff);
      yx = (DATA_W+3)'(yaw_fin);
      sum[0] = tx + rx - px + yx;
      sum[1] = tx - rx - px - yx;
      sum[2] = tx + rx + px - yx;
      sum[3] = tx - rx + px + yx;
      for (int i = 0; i < LANES; i++) begin
         thr_in[i] = sat_s32(64'(sum[i] >>> 2));
      end
   end

   always_comb begin
      mprod = '0;
      for (int i = 0; i < LANES; i++) begin
         mprod = thr1_ff[i][DATA_W-2:0] * inv_thrust;
         rad_in[i] = (thr1_ff[i] > 0) ? {1'b0, mprod} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= in_valid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         prod0_ff <= prod_full[63:0];
         t0_ff <= total_thrust;
         r0_ff <= roll_moment;
         p0_ff <= pitch_moment;
         now0_ff <= now_vel;
      end
      if (en1) begin
         thr1_ff <= thr_in;
         now1_ff <= now0_ff;
      end
      if (en2) begin
         rad2_ff <= rad_in;
         now2_ff <= now1_ff;
      end
   end

   assign rad = rad2_ff;
   assign now_out = now2_ff;
endmodule
`default_nettype wire

// ===== sv/qmm_sqrt.sv =====
// iterative square root lane, two result bits per cycle
`default_nettype none
module qmm_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [qmm_pkg::RAD_W-1:0] rad,
   input  logic out_ready,
   output qmm_pkg::lane_hs_type hs,
   output logic [qmm_pkg::ROOT_W-1:0] root
);
   import qmm_pkg::*;

   localparam logic [SCNT_W-1:0] LAST = SCNT_W'(SQRT_CYCLES - 1);

   logic busy_ff, done_ff;
   logic [SCNT_W-1:0] cnt_ff;
   logic [RAD_W-1:0] rad_ff, rad_in;
   sqrt_acc_type acc_ff, acc_in;
   logic start;

   always_comb begin
      hs.in_ready = !busy_ff && (!done_ff || out_ready);
      hs.out_valid = done_ff;
      start = in_valid && hs.in_ready;
      acc_in = acc_ff;
      rad_in = rad_ff;
      for (int k = 0; k < SQRT_PER_CYC; k++) begin
         acc_in = sqrt_step(acc_in, rad_in[RAD_W-1 -: 2]);
         rad_in = {rad_in[RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else if (done_ff && out_ready) begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff <= rad;
         acc_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= rad_in;
         acc_ff <= acc_in;
      end
   end

   assign root = acc_ff.root;
endmodule
`default_nettype wire

// ===== sv/qmm_merge.sv =====
// velocity deltas of the four lanes, largest change and ramp decision
`default_nettype none
module qmm_merge (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [qmm_pkg::ROOT_W-1:0] root [qmm_pkg::LANES],
   input  qmm_pkg::sword_type now_vel [qmm_pkg::LANES],
   input  logic ramp_en,
   input  logic [qmm_pkg::MAXDV_W-1:0] max_dv,
   output logic out_valid,
   input  logic out_ready,
   output logic [qmm_pkg::PROD_W-1:0] prod [qmm_pkg::LANES],
   output qmm_pkg::uword_type max_abs,
   output logic limited,
   output qmm_pkg::sword_type vel [qmm_pkg::LANES],
   output qmm_pkg::sword_type now_out [qmm_pkg::LANES],
   output logic [qmm_pkg::LANES-1:0] neg
);
   import qmm_pkg::*;

   logic v1_ff, v2_ff, en1, en2;
   sword_type vel_in [LANES];
   sword_type vel1_ff [LANES];
   sword_type vel2_ff [LANES];
   sword_type now1_ff [LANES];
   sword_type now2_ff [LANES];
   logic [LANES-1:0] neg_in, neg1_ff, neg2_ff;
   uword_type mag_in [LANES];
   uword_type mag1_ff [LANES];
   logic signed [DATA_W+1:0] delta, mag_full;
   uword_type mx_a, mx_b, mx_in, mx2_ff;
   logic lim_in, lim2_ff;
   logic [PROD_W-1:0] prod_in [LANES];
   logic [PROD_W-1:0] prod2_ff [LANES];

   always_comb begin
      en2 = !v2_ff || out_ready;
      en1 = !v1_ff || en2;
      in_ready = en1;
      out_valid = v2_ff;
      delta = '0;
      mag_full = '0;
      for (int i = 0; i < LANES; i++) begin
         vel_in[i] = (root[i] > uword_type'(S32_MAX)) ? S32_MAX : sword_type'(root[i]);
         delta = (DATA_W+2)'(vel_in[i]) - (DATA_W+2)'(now_vel[i]);
         neg_in[i] = delta[DATA_W+1];
         mag_full = neg_in[i] ? -delta : delta;
         mag_in[i] = mag_full[DATA_W-1:0];
      end
   end

   // largest change over a two-level compare tree, products in parallel
   always_comb begin
      mx_a = (mag1_ff[0] > mag1_ff[1]) ? mag1_ff[0] : mag1_ff[1];
      mx_b = (mag1_ff[2] > mag1_ff[3]) ? mag1_ff[2] : mag1_ff[3];
      mx_in = (mx_a > mx_b) ? mx_a : mx_b;
      lim_in = ramp_en && (mx_in > {1'b0, max_dv});
      for (int i = 0; i < LANES; i++) begin
         prod_in[i] = mag1_ff[i] * max_dv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         vel1_ff <= vel_in;
         now1_ff <= now_vel;
         neg1_ff <= neg_in;
         mag1_ff <= mag_in;
      end
      if (en2) begin
         vel2_ff <= vel1_ff;
         now2_ff <= now1_ff;
         neg2_ff <= neg1_ff;
         prod2_ff <= prod_in;
         mx2_ff <= mx_in;
         lim2_ff <= lim_in;
      end
   end

   assign prod = prod2_ff;
   assign max_abs = mx2_ff;
   assign limited = lim2_ff;
   assign vel = vel2_ff;
   assign now_out = now2_ff;
   assign neg = neg2_ff;
endmodule
`default_nettype wire

// ===== sv/qmm_div.sv =====
// iterative restoring divide lane, two quotient bits per cycle
`default_nettype none
module qmm_div (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [qmm_pkg::PROD_W-1:0] num,
   input  qmm_pkg::uword_type den,
   input  logic out_ready,
   output qmm_pkg::lane_hs_type hs,
   output qmm_pkg::uword_type quo
);
   import qmm_pkg::*;

   localparam logic [DCNT_W-1:0] LAST = DCNT_W'(DIV_CYCLES - 1);

   logic busy_ff, done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] low_ff, low_in;
   uword_type den_ff;
   div_acc_type acc_ff, acc_in;
   logic start;

   always_comb begin
      hs.in_ready = !busy_ff && (!done_ff || out_ready);
      hs.out_valid = done_ff;
      start = in_valid && hs.in_ready;
      acc_in = acc_ff;
      low_in = low_ff;
      for (int k = 0; k < DIV_PER_CYC; k++) begin
         acc_in = div_step(acc_in, low_in[DIV_W-1], den_ff);
         low_in = {low_in[DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else if (done_ff && out_ready) begin
         done_ff <= 1'b0;
      end
   end

   // upper dividend bits stay below the divisor, so the quotient fits one word
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff.rem <= DIV_W'(num[PROD_W-1:DIV_W]);
         acc_ff.quo <= '0;
         low_ff <= num[DIV_W-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         low_ff <= low_in;
      end
   end

   assign quo = acc_ff.quo;
endmodule
`default_nettype wire

// ===== test/quad_motor_mixer_ramp_limit_tb.sv =====
// testbench for the quad motor mixer: directed and random requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module quad_motor_mixer_ramp_limit_tb;
   import qmm_pkg::*;

   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 80;
   localparam longint S_MAX   = 64'sd2147483647;
   localparam longint S_MIN   = -64'sd2147483648;

   typedef struct {
      sword_type thrust, roll, pitch, yaw;
      sword_type now_v[4];
   } mix_request_type;

   typedef struct {
      sword_type vel[4];
      logic      limited;
   } motor_command_type;

   class mixer_scoreboard;
      logic [31:0] yaw_gain, inv_thrust;
      logic        yaw_rev, ramp_on;
      logic [30:0] max_dv;
      motor_command_type pending[$];
      int mismatches, checked, limited_seen;

      function new();
         yaw_gain = 32'h0001_0000;
         inv_thrust = 32'h0001_0000;
         yaw_rev = 1'b0;
         ramp_on = 1'b1;
         max_dv = 31'h0001_0000;
      endfunction

      function longint clamp32(longint v);
         if (v > S_MAX) return S_MAX;
         if (v < S_MIN) return S_MIN;
         return v;
      endfunction

      function longint unsigned root_floor(longint unsigned x);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function motor_command_type mix(mix_request_type rq);
         motor_command_type c;
         longint t, r, p, y, thr;
         longint sum[4], vel[4], now[4], delta[4];
         longint unsigned mag[4], maxabs, rt, sc;
         t = rq.thrust;
         r = rq.roll;
         p = rq.pitch;
         y = longint'(rq.yaw) * longint'({32'd0, yaw_gain});
         y = clamp32(y >>> 16);
         if (yaw_rev) y = clamp32(-y);
         sum[0] = t + r - p + y;
         sum[1] = t - r - p - y;
         sum[2] = t + r + p - y;
         sum[3] = t - r + p + y;
         maxabs = 0;
         for (int i = 0; i < 4; i++) begin
            now[i] = rq.now_v[i];
            thr = clamp32(sum[i] >>> 2);
            if (thr <= 0) begin
               vel[i] = 0;
            end else begin
               rt = root_floor(longint'(thr) * longint'({32'd0, inv_thrust}));
               vel[i] = (rt > S_MAX) ? S_MAX : longint'(rt);
            end
            delta[i] = vel[i] - now[i];
            mag[i] = (delta[i] < 0) ? -delta[i] : delta[i];
            if (mag[i] > maxabs) maxabs = mag[i];
         end
         c.limited = 1'b0;
         if (ramp_on && maxabs > max_dv) begin
            c.limited = 1'b1;
            for (int i = 0; i < 4; i++) begin
               sc = (mag[i] * longint'({33'd0, max_dv})) / maxabs;
               vel[i] = clamp32(delta[i] < 0 ? now[i] - longint'(sc) : now[i] + longint'(sc));
            end
         end
         for (int i = 0; i < 4; i++) c.vel[i] = vel[i][31:0];
         return c;
      endfunction

      function void note_request(mix_request_type rq);
         pending.push_back(mix(rq));
      endfunction

      function void check_command(motor_command_type got);
         motor_command_type want;
         bit bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.limited) limited_seen++;
         bad = (want.limited !== got.limited);
         for (int i = 0; i < 4; i++) if (want.vel[i] !== got.vel[i]) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: expected %h %h %h %h lim %b, got %h %h %h %h lim %b",
                        checked, want.vel[0], want.vel[1], want.vel[2], want.vel[3],
                        want.limited, got.vel[0], got.vel[1], got.vel[2], got.vel[3],
                        got.limited);
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_wdata;
   qmm_req_if req_bus();
   qmm_rsp_if rsp_bus();

   quad_motor_mixer_ramp_limit u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_bus.sink), .rsp_chan(rsp_bus.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   mixer_scoreboard sb = new();
   int idle_cycles;
   int sent;
   int settings_used;
   bit rsp_no_stall;
   bit send_no_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request/response monitor and watchdog
   always @(posedge clock) begin
      mix_request_type rq;
      motor_command_type rc;
      if (!reset) begin
         idle_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            rq.thrust = req_bus.total_thrust;
            rq.roll = req_bus.roll_moment;
            rq.pitch = req_bus.pitch_moment;
            rq.yaw = req_bus.yaw_moment;
            rq.now_v[0] = req_bus.now_vel_fl;
            rq.now_v[1] = req_bus.now_vel_fr;
            rq.now_v[2] = req_bus.now_vel_rl;
            rq.now_v[3] = req_bus.now_vel_rr;
            sb.note_request(rq);
            idle_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rc.vel[0] = rsp_bus.out_vel_fl;
            rc.vel[1] = rsp_bus.out_vel_fr;
            rc.vel[2] = rsp_bus.out_vel_rl;
            rc.vel[3] = rsp_bus.out_vel_rr;
            rc.limited = rsp_bus.ramp_limited;
            sb.check_command(rc);
            idle_cycles = 0;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // response side with random stalls
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = rsp_no_stall ? 0 : $urandom_range(0, 11);
         if (n > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         @(negedge clock);
      end
   end

   task automatic write_csr(csr_idx_type idx, logic [31:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_YAW_GAIN:    sb.yaw_gain = val;
         CSR_INV_THRUST:  sb.inv_thrust = val;
         CSR_YAW_REVERSE: sb.yaw_rev = val[0];
         CSR_RAMP_ENABLE: sb.ramp_on = val[0];
         CSR_MAX_DELTA_V: sb.max_dv = val[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // waits for every outstanding response, then lets the pipeline settle
   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic load_setting(logic [31:0] g, logic [31:0] inv, logic rev, logic ramp,
                               logic [31:0] dv);
      drain();
      write_csr(CSR_YAW_GAIN, g);
      write_csr(CSR_INV_THRUST, inv);
      write_csr(CSR_YAW_REVERSE, {31'd0, rev});
      write_csr(CSR_RAMP_ENABLE, {31'd0, ramp});
      write_csr(CSR_MAX_DELTA_V, dv);
      settings_used++;
   endtask

   task automatic send_request(mix_request_type rq);
      int n;
      n = send_no_gap ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
         req_bus.valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.total_thrust = rq.thrust;
      req_bus.roll_moment = rq.roll;
      req_bus.pitch_moment = rq.pitch;
      req_bus.yaw_moment = rq.yaw;
      req_bus.now_vel_fl = rq.now_v[0];
      req_bus.now_vel_fr = rq.now_v[1];
      req_bus.now_vel_rl = rq.now_v[2];
      req_bus.now_vel_rr = rq.now_v[3];
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
      req_bus.valid = 1'b0;
      sent++;
   endtask

   function automatic sword_type rand_word();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         3: begin
            case ($urandom_range(0, 3))
               0: return S32_MAX;
               1: return S32_MIN;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom_range(0, 32'h0400_0000);
      endcase
   endfunction

   function automatic mix_request_type rand_request();
      mix_request_type rq;
      rq.thrust = rand_word();
      rq.roll = rand_word();
      rq.pitch = rand_word();
      rq.yaw = rand_word();
      for (int i = 0; i < 4; i++) rq.now_v[i] = rand_word();
      return rq;
   endfunction

   function automatic mix_request_type make_request(sword_type t, sword_type r, sword_type p,
                                                    sword_type y, sword_type v);
      mix_request_type rq;
      rq.thrust = t;
      rq.roll = r;
      rq.pitch = p;
      rq.yaw = y;
      for (int i = 0; i < 4; i++) rq.now_v[i] = v;
      return rq;
   endfunction

   task automatic random_burst(int count);
      for (int k = 0; k < count; k++) send_request(rand_request());
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.total_thrust = '0;
      req_bus.roll_moment = '0;
      req_bus.pitch_moment = '0;
      req_bus.yaw_moment = '0;
      req_bus.now_vel_fl = '0;
      req_bus.now_vel_fr = '0;
      req_bus.now_vel_rl = '0;
      req_bus.now_vel_rr = '0;
      rsp_no_stall = 1'b0;
      send_no_gap = 1'b0;
      sent = 0;
      settings_used = 1;
      idle_cycles = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset defaults: zero, extremes, negative thrust, small changes under the ramp limit
      send_request(make_request(0, 0, 0, 0, 0));
      send_request(make_request(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
      send_request(make_request(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
      send_request(make_request(S32_MAX, S32_MIN, S32_MAX, S32_MIN, 0));
      send_request(make_request(-32'sd65536, 0, 0, 0, 32'sd65536));
      send_request(make_request(32'sd4 <<< 16, 0, 0, 0, 32'sd65536));
      send_request(make_request(32'sd4 <<< 16, 0, 0, 0, 32'sd131072));
      send_request(make_request(32'sd4 <<< 16, 32'sd65536, 0, 0, 32'sd65536));
      send_request(make_request(32'sd8 <<< 16, 0, 32'sd65536, 0, 32'sd65536));
      send_request(make_request(32'sd8 <<< 16, 0, 0, 32'sd65536, S32_MIN));
      send_request(make_request(32'sd8 <<< 16, 0, 0, 0, S32_MAX));
      send_request(make_request(S32_MAX, 0, 0, 0, S32_MIN));
      random_burst(290);

      // yaw reversal with most negative yaw saturates, ramp off
      load_setting(32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0, 32'h0001_0000);
      rsp_no_stall = 1'b1;
      send_no_gap = 1'b1;
      send_request(make_request(0, 0, 0, S32_MIN, 0));
      send_request(make_request(0, 0, 0, S32_MAX, 0));
      send_request(make_request(32'sd4 <<< 16, 0, 0, -32'sd65536, 0));
      send_request(make_request(S32_MAX, 0, 0, S32_MIN, S32_MAX));
      random_burst(200);
      rsp_no_stall = 1'b0;
      send_no_gap = 1'b0;

      // largest coefficients, ramp enabled with the largest allowed change
      load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF);
      send_request(make_request(0, 0, 0, S32_MIN, 0));
      send_request(make_request(S32_MAX, 0, 0, S32_MAX, S32_MIN));
      random_burst(200);

      // zero coefficients and zero allowed change
      load_setting(32'h0, 32'h0, 1'b1, 1'b1, 32'h0);
      send_request(make_request(S32_MAX, 0, 0, 0, 32'sd5));
      random_burst(150);

      for (int ph = 0; ph < 4; ph++) begin
         load_setting($urandom(), $urandom_range(0, 32'h0010_0000), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 32'h0040_0000));
         rsp_no_stall = (ph == 2);
         send_no_gap = (ph == 2);
         random_burst(200);
      end
      rsp_no_stall = 1'b0;
      send_no_gap = 1'b0;

      drain();
      $display("sent %0d requests across %0d register settings, %0d responses checked",
               sent, settings_used, sb.checked);
      $display("%0d responses were ramp limited, %0d mismatches counted",
               sb.limited_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire
